@@ src/olad_pkg.sv @@
// Package for the ordered list block: default depth, command and status codes,
// sequencer states and the control word broadcast to the storage cells.
// Used by olad_cell and ordered_list_append_delete_top; depends on nothing.
package olad_pkg;

  localparam int DEFAULT_LIST_DEPTH = 16;
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_STATUS
  } state_t;

  // Control word shared by every cell of the chain.
  typedef struct packed {
    logic wr;    // store wdata in the cell at the tail position
    logic rot;   // rotate the occupied part of the ring by one toward the head
    logic drop;  // shift toward the head without wrapping, removing the head
  } cell_ctrl_t;

endpackage

@@ src/olad_cell.sv @@
// One storage cell of the ordered list ring: holds a single entry and loads
// from its right neighbor, from the head or from the write bus. Uses olad_pkg.
module olad_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                             clk,
  input  olad_pkg::cell_ctrl_t             ctrl,
  input  logic [CW-1:0]                    wr_idx,
  input  logic [CW-1:0]                    last_idx,
  input  logic [olad_pkg::VALUE_W-1:0]     wdata,
  input  logic [olad_pkg::VALUE_W-1:0]     right_data,
  input  logic [olad_pkg::VALUE_W-1:0]     head_data,
  output logic [olad_pkg::VALUE_W-1:0]     q
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [olad_pkg::VALUE_W-1:0] q_r;
  logic [olad_pkg::VALUE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.wr && (MY_IDX == wr_idx)) begin
      q_nxt = wdata;
    end else if ((ctrl.rot || ctrl.drop) && (MY_IDX < last_idx)) begin
      q_nxt = right_data;
    end else if (ctrl.rot && (MY_IDX == last_idx)) begin
      // The old head wraps around to the tail of the occupied part.
      q_nxt = head_data;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ src/ordered_list_append_delete_top.sv @@
// Ordered list of signed 32-bit values held in a ring of storage cells.
// Append and read out: the request moves the sequencer to S_READ, which registers
// one entry per cycle while the output is free (one item for an empty list or a status).
// Delete: a search pass over every entry rotates the ring once, then the read out or a status.
// A new request is taken once the last result of the previous one is registered.
// Reset (rst_n low, synchronous) empties the list; the cells themselves are not cleared.
module ordered_list_append_delete_top #(
  parameter int LIST_DEPTH = olad_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] element
  output logic [2:0]  out_tuser,  // [1:0] status, [2] has_element
  output logic        out_tlast
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);
  localparam int VW = olad_pkg::VALUE_W;

  olad_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      pass_len_r, pass_len_nxt;
  logic               found_r, found_nxt;
  logic [VW-1:0]      key_r, key_nxt;
  olad_pkg::status_t  stat_r, stat_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [VW-1:0]      out_elem_r, out_elem_nxt;
  olad_pkg::status_t  out_stat_r, out_stat_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_last_r, out_last_nxt;

  olad_pkg::cell_ctrl_t ctrl;
  logic [VW-1:0]      cell_q [LIST_DEPTH];
  logic [CW-1:0]      last_idx;
  logic               in_req;
  logic               out_free;
  logic               is_last_read;
  logic               is_last_search;
  logic               hit;
  olad_pkg::cmd_t     cmd;

  assign in_tready      = (state_r == olad_pkg::S_IDLE);
  assign in_req         = in_tvalid && in_tready;
  assign out_free       = !out_valid_r || out_tready;
  assign cmd            = olad_pkg::cmd_t'(in_tuser);
  assign last_idx       = cnt_r - CW'(1);
  assign is_last_read   = (step_r == last_idx);
  assign is_last_search = (step_r == pass_len_r - CW'(1));
  assign hit            = !found_r && (cell_q[0] == key_r);

  // Chain of cells; the last cell's right input is tied to the head and it never loads from it.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [VW-1:0] right;
    if (i == LIST_DEPTH - 1) begin : g_end
      assign right = cell_q[0];
    end else begin : g_mid
      assign right = cell_q[i+1];
    end
    olad_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_idx     (cnt_r),
      .last_idx   (last_idx),
      .wdata      (in_tdata),
      .right_data (right),
      .head_data  (cell_q[0]),
      .q          (cell_q[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olad_pkg::S_IDLE: begin
        if (in_req) begin
          case (cmd)
            olad_pkg::CMD_APPEND: begin
              state_nxt = (cnt_r == FULL_CNT) ? olad_pkg::S_STATUS : olad_pkg::S_READ;
            end
            olad_pkg::CMD_DELETE: begin
              state_nxt = (cnt_r == '0) ? olad_pkg::S_STATUS : olad_pkg::S_SEARCH;
            end
            olad_pkg::CMD_READ: begin
              state_nxt = olad_pkg::S_READ;
            end
            default: begin
              state_nxt = olad_pkg::S_IDLE;
            end
          endcase
        end
      end
      olad_pkg::S_SEARCH: begin
        if (is_last_search) begin
          state_nxt = (found_r || hit) ? olad_pkg::S_READ : olad_pkg::S_STATUS;
        end
      end
      olad_pkg::S_READ: begin
        if (out_free && ((cnt_r == '0) || is_last_read)) begin
          state_nxt = olad_pkg::S_IDLE;
        end
      end
      olad_pkg::S_STATUS: begin
        if (out_free) begin
          state_nxt = olad_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = olad_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath control and result loading.
  always_comb begin
    ctrl          = '0;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    pass_len_nxt  = pass_len_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_elem_nxt  = out_elem_r;
    out_stat_nxt  = out_stat_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      olad_pkg::S_IDLE: begin
        step_nxt  = '0;
        found_nxt = 1'b0;
        if (in_req) begin
          key_nxt      = in_tdata;
          pass_len_nxt = cnt_r;
          case (cmd)
            olad_pkg::CMD_APPEND: begin
              if (cnt_r == FULL_CNT) begin
                stat_nxt = olad_pkg::ST_FULL;
              end else begin
                ctrl.wr = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            olad_pkg::CMD_DELETE: begin
              stat_nxt = olad_pkg::ST_EMPTY;
            end
            default: begin
            end
          endcase
        end
      end
      olad_pkg::S_SEARCH: begin
        // The first equal entry is dropped as it reaches the head; the others rotate.
        if (hit) begin
          ctrl.drop = 1'b1;
          cnt_nxt   = cnt_r - CW'(1);
          found_nxt = 1'b1;
        end else begin
          ctrl.rot = 1'b1;
        end
        stat_nxt = olad_pkg::ST_NOT_FOUND;
        step_nxt = is_last_search ? '0 : step_r + CW'(1);
      end
      olad_pkg::S_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = olad_pkg::ST_OK;
          if (cnt_r == '0) begin
            out_has_nxt  = 1'b0;
            out_elem_nxt = '0;
            out_last_nxt = 1'b1;
          end else begin
            out_has_nxt  = 1'b1;
            out_elem_nxt = cell_q[0];
            out_last_nxt = is_last_read;
            ctrl.rot     = 1'b1;
            step_nxt     = step_r + CW'(1);
          end
        end
      end
      olad_pkg::S_STATUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_has_nxt   = 1'b0;
          out_elem_nxt  = '0;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olad_pkg::S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_len_r <= pass_len_nxt;
    key_r      <= key_nxt;
    stat_r     <= stat_nxt;
    out_elem_r <= out_elem_nxt;
    out_stat_r <= out_stat_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_elem_r;
  assign out_tuser  = {out_has_r, out_stat_r};
  assign out_tlast  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count exceeds list depth");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_last_r && (out_elem_r == '0))
    else $error("item without element must be a zeroed single last item");

  a_search_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == olad_pkg::S_SEARCH |=>
      (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("search pass removed more than one entry at once");

  a_single_drop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == olad_pkg::S_SEARCH && found_r |=> cnt_r == $past(cnt_r))
    else $error("second entry dropped in one delete");

endmodule

@@ tb/tb_ordered_list_append_delete_top.sv @@
// Self-checking testbench for ordered_list_append_delete_top: directed and random
// append, delete and read out requests, checked against a list kept in the bench.
// Depends on olad_pkg and the RTL of the top level only.
module tb_ordered_list_append_delete_top;

  localparam int LIST_DEPTH = olad_pkg::DEFAULT_LIST_DEPTH;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 4 * LIST_DEPTH + 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    olad_pkg::status_t status;
    logic              has_element;
    logic [31:0]       element;
    logic              last;
  } list_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  logic [31:0]  list_entries[$];
  list_result_t pending_results[$];
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;

  ordered_list_append_delete_top #(.LIST_DEPTH(LIST_DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic push_single_status(input olad_pkg::status_t st);
    list_result_t r;
    r.status      = st;
    r.has_element = 1'b0;
    r.element     = '0;
    r.last        = 1'b1;
    pending_results.push_back(r);
  endtask

  task automatic push_list_readout();
    list_result_t r;
    if (list_entries.size() == 0) begin
      push_single_status(olad_pkg::ST_OK);
    end else begin
      foreach (list_entries[k]) begin
        r.status      = olad_pkg::ST_OK;
        r.has_element = 1'b1;
        r.element     = list_entries[k];
        r.last        = (k == list_entries.size() - 1);
        pending_results.push_back(r);
      end
    end
  endtask

  // Updates the bench copy of the list and queues the results the request causes.
  task automatic apply_list_command(input logic [1:0] cmd, input logic [31:0] value);
    int hit;
    hit = -1;
    if (cmd == olad_pkg::CMD_APPEND) begin
      if (list_entries.size() >= LIST_DEPTH) begin
        push_single_status(olad_pkg::ST_FULL);
      end else begin
        list_entries.push_back(value);
        push_list_readout();
      end
    end else if (cmd == olad_pkg::CMD_DELETE) begin
      if (list_entries.size() == 0) begin
        push_single_status(olad_pkg::ST_EMPTY);
      end else begin
        foreach (list_entries[k])
          if (hit < 0 && list_entries[k] == value) hit = k;
        if (hit < 0) begin
          push_single_status(olad_pkg::ST_NOT_FOUND);
        end else begin
          list_entries.delete(hit);
          push_list_readout();
        end
      end
    end else if (cmd == olad_pkg::CMD_READ) begin
      push_list_readout();
    end
  endtask

  // Offers one request, with random gaps ahead of it, and returns once it is taken.
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_list_command(cmd, value);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_special_cases();
    send_request(olad_pkg::CMD_READ, $urandom);          // read out of the empty list
    send_request(olad_pkg::CMD_DELETE, 32'd5);           // delete on the empty list
    send_request(CMD_UNUSED, $urandom);                  // ignored, no result
    send_request(olad_pkg::CMD_APPEND, 32'h7fff_ffff);
    send_request(olad_pkg::CMD_DELETE, 32'h0000_0000);   // value not in the list
    send_request(olad_pkg::CMD_DELETE, 32'h7fff_ffff);   // delete that empties the list
    send_request(olad_pkg::CMD_APPEND, 32'h8000_0000);
    send_request(olad_pkg::CMD_APPEND, 32'hffff_ffff);
    send_request(olad_pkg::CMD_APPEND, 32'h0000_0000);
    send_request(olad_pkg::CMD_APPEND, 32'hffff_ffff);
    send_request(olad_pkg::CMD_APPEND, 32'h7fff_ffff);
    send_request(olad_pkg::CMD_DELETE, 32'hffff_ffff);   // only the first equal entry goes
    send_request(olad_pkg::CMD_DELETE, 32'hffff_ffff);   // now the second to last entry
    send_request(olad_pkg::CMD_DELETE, 32'h8000_0000);   // head
    send_request(olad_pkg::CMD_DELETE, 32'h7fff_ffff);   // tail
  endtask

  task automatic test_full_list();
    logic [31:0] second_last;
    while (list_entries.size() < LIST_DEPTH)
      send_request(olad_pkg::CMD_APPEND, random_value());
    send_request(olad_pkg::CMD_APPEND, $urandom);        // list full, nothing stored
    second_last = list_entries[LIST_DEPTH - 2];
    send_request(olad_pkg::CMD_DELETE, second_last);
    send_request(olad_pkg::CMD_READ, $urandom);
  endtask

  task automatic test_random_mix(input int n_items);
    int          done;
    int          r;
    logic [1:0]  cmd;
    logic [31:0] value;
    done = 0;
    while (done < n_items) begin
      r     = $urandom_range(99);
      value = random_value();
      if (r < 6) begin
        cmd = CMD_UNUSED;
      end else if (r < 6 + (list_entries.size() < LIST_DEPTH - 4 ? 46 : 22)) begin
        cmd = olad_pkg::CMD_APPEND;
      end else if (r < 82) begin
        cmd = olad_pkg::CMD_DELETE;
        // Mostly hit an entry that is present so that the compaction is exercised.
        if (list_entries.size() > 0 && $urandom_range(99) < 70)
          value = list_entries[$urandom_range(list_entries.size() - 1)];
      end else begin
        cmd = olad_pkg::CMD_READ;
      end
      send_request(cmd, value);
      if (cmd != CMD_UNUSED) done++;
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (20) begin
      if (list_entries.size() < LIST_DEPTH && $urandom_range(1) == 0)
        send_request(olad_pkg::CMD_APPEND, $urandom);
      else
        send_request(olad_pkg::CMD_READ, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, element", out_tdata, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[1:0] != want.status)
          report_mismatch("status", 32'(out_tuser[1:0]), 32'(want.status));
        if (out_tuser[2] != want.has_element)
          report_mismatch("has_element", 32'(out_tuser[2]), 32'(want.has_element));
        if (out_tdata != want.element)
          report_mismatch("element", out_tdata, want.element);
        if (out_tlast != want.last)
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    int waited;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= olad_pkg::CMD_APPEND;
    out_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 12;
    recv_stall_pct = 60;
    test_special_cases();
    test_full_list();
    test_random_mix(115);

    send_idle_pct  = 60;
    recv_stall_pct = 12;
    test_random_mix(115);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(115);
    test_output_stall();
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("results still missing", 32'(pending_results.size()), 32'h0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/olad_pkg.sv
src/olad_cell.sv
src/ordered_list_append_delete_top.sv
tb/tb_ordered_list_append_delete_top.sv
